### hdl/sha256_stream_hasher_unit_assert.svh
// assertion macros for the stream hasher
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SHA_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define SHA_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

### hdl/sha256_pkg.sv
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	localparam logic [2:0] REG_IV_SELECT = 3'd0;
	localparam logic [2:0] REG_IV_01     = 3'd1;
	localparam logic [2:0] REG_IV_23     = 3'd2;
	localparam logic [2:0] REG_IV_45     = 3'd3;
	localparam logic [2:0] REG_IV_67     = 3'd4;
	localparam logic [2:0] REG_LEN_OFS   = 3'd5;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] std_iv(input logic [2:0] i);
		logic [31:0] v [8];
		v = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
			32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
		return v[i];
	endfunction

endpackage

### hdl/sha256_stream_hasher_unit.sv
// SHA-256 over a byte stream.
// Input s_axis: tdata = data_byte [7:0]; tlast = last_byte; tuser = no_byte.
// A last word closes the message: padding and the length field are added
// and the digest goes out on m_axis as eight words, word 0 first.
// m_axis tdata = {word_index [34:32], digest_word [31:0]} in 40 bits, tlast
// marks word 7.
// Bytes go to a 16x32 block memory and are taken only while idle. A byte
// that fills the block starts compression: 16 load + 48 schedule rounds
// (memory read at one port), plus an add step.
// A last word adds padding (the 0x80 byte, zero writes and the length) and
// one or two compressions, then the digest words go out; a stalled receiver holds each word.
// Config is a write port: cfg_we, cfg_addr (register index), cfg_wdata.
// Reset clears control state; chaining value loads from the selected IV on
// the first word of each message.
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,
	input  logic        s_axis_tuser,  // no_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word, word_index, zero fill
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);
	import sha256_pkg::*;
`include "sha256_stream_hasher_unit_assert.svh"

	state_t state_q, state_d;
	logic        iv_sel_q;
	logic [63:0] iv_q [4];
	logic [31:0] len_ofs_q;
	logic [5:0]  fill_q;
	logic [60:0] cnt_q;
	logic        open_q;
	logic        final_q;
	logic [31:0] cv_q [8];
	logic [255:0] wk_q;
	logic [6:0]  rnd_q;
	logic [31:0] win_q [16];
	logic [2:0]  oidx_q;
	logic [31:0] word_q;
	// padding_q: message closing; final_q: block carries the length;
	// two_q: one more pad block follows this compression
	logic padding_q, two_q;

	// block memory, byte lanes merged with a held copy of the current word
	logic        bwe;
	logic [3:0]  bwaddr, braddr;
	logic [31:0] bwdata, brdata;
	sha256_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
		.clk(clk), .we(bwe), .waddr(bwaddr), .wdata(bwdata),
		.raddr(braddr), .rdata(brdata));

	logic acc, has_byte;
	logic [31:0] wt, s0, s1, w15, w2;
	logic [255:0] rnext;
	logic [63:0] len_sum;
	logic [63:0] bits;
	logic [5:0]  fill_nx;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;
	assign has_byte = !s_axis_tuser;
	assign fill_nx = fill_q + 6'd1;

	always_comb begin
		w15 = win_q[1];
		w2  = win_q[14];
		s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		wt = (rnd_q < 7'd16) ? brdata : s1 + win_q[9] + s0 + win_q[0];
	end

	sha256_round u_round (.abcd(wk_q), .kw(wt + round_k(rnd_q[5:0])), .next(rnext));

	assign len_sum = {3'd0, cnt_q} + {32'd0, len_ofs_q};
	assign bits = {len_sum[60:0], 3'd0};

	// pad sequence: fill_q walks from the 0x80 slot (or from 0 in a second pad block) to the end of the block
	always_comb begin
		bwe = 1'b0;
		bwaddr = fill_q[5:2];
		bwdata = word_q;
		braddr = rnd_q[3:0];
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (has_byte || s_axis_tlast)) begin
					if (has_byte) begin
						bwe = 1'b1;
						case (fill_q[1:0])
							2'd0: bwdata = {s_axis_tdata, 24'd0};
							2'd1: bwdata = {word_q[31:24], s_axis_tdata, 16'd0};
							2'd2: bwdata = {word_q[31:16], s_axis_tdata, 8'd0};
							default: bwdata = {word_q[31:8], s_axis_tdata};
						endcase
					end
					if (has_byte && fill_q == 6'd63)
						state_d = ST_LOAD;
					else if (s_axis_tlast)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				bwe = 1'b1;
				if (fill_q[5:2] == 4'd14 && final_q)
					bwdata = bits[63:32];
				else if (fill_q[5:2] == 4'd15 && final_q)
					bwdata = bits[31:0];
				else
					case (fill_q[1:0])
						2'd0: bwdata = {(open_q ? PAD_BYTE : 8'd0), 24'd0};
						2'd1: bwdata = {word_q[31:24], (open_q ? PAD_BYTE : 8'd0), 16'd0};
						2'd2: bwdata = {word_q[31:16], (open_q ? PAD_BYTE : 8'd0), 8'd0};
						default: bwdata = {word_q[31:8], (open_q ? PAD_BYTE : 8'd0)};
					endcase
				if (fill_q == 6'd63)
					state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: begin
				braddr = rnd_q[3:0] + 4'd1;
				if (rnd_q == 7'd63)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (padding_q && two_q)
					state_d = ST_PAD;
				else if (padding_q)
					state_d = ST_OUT;
				else
					state_d = ST_IDLE;
			end
			ST_OUT: begin
				if (m_axis_tready && oidx_q == 3'd7)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iv_sel_q <= 1'b0;
			for (int i = 0; i < 4; i++) iv_q[i] <= '0;
			len_ofs_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			open_q <= 1'b0;
			final_q <= 1'b0;
			padding_q <= 1'b0;
			two_q <= 1'b0;
			rnd_q <= '0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= std_iv(3'(i));
		end else begin
			state_q <= state_d;
			if (cfg_we)
				case (cfg_addr)
					REG_IV_SELECT: iv_sel_q <= cfg_wdata[0];
					REG_IV_01: iv_q[0] <= cfg_wdata;
					REG_IV_23: iv_q[1] <= cfg_wdata;
					REG_IV_45: iv_q[2] <= cfg_wdata;
					REG_IV_67: iv_q[3] <= cfg_wdata;
					REG_LEN_OFS: len_ofs_q <= cfg_wdata[31:0];
					default: ;
				endcase
			case (state_q)
				ST_IDLE: begin
					if (acc && (has_byte || s_axis_tlast)) begin
						if (!open_q) begin
							for (int i = 0; i < 8; i++)
								cv_q[i] <= iv_sel_q ? (i[0] ? iv_q[i/2][31:0] : iv_q[i/2][63:32])
									: std_iv(3'(i));
						end
						open_q <= 1'b1;
						if (has_byte) begin
							fill_q <= fill_q + 6'd1;
							cnt_q <= (open_q ? cnt_q : 61'd0) + 61'd1;
						end else if (!open_q)
							cnt_q <= '0;
						if (s_axis_tlast) begin
							padding_q <= 1'b1;
							// 0x80 slot plus room for length decides one or two blocks
							final_q <= ((has_byte ? fill_q + 6'd1 : fill_q) < 6'd56)
								&& !(has_byte && fill_q == 6'd63);
							two_q <= !(((has_byte ? fill_q + 6'd1 : fill_q) < 6'd56)
								&& !(has_byte && fill_q == 6'd63));
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					open_q <= 1'b0;
				end
				ST_LOAD: rnd_q <= '0;
				ST_ROUND: rnd_q <= rnd_q + 7'd1;
				ST_ADD: begin
					fill_q <= '0;
					if (padding_q) begin
						if (two_q) begin
							two_q <= 1'b0;
							final_q <= 1'b1;
						end else begin
							padding_q <= 1'b0;
							final_q <= 1'b0;
							oidx_q <= '0;
						end
					end
				end
				ST_OUT: if (m_axis_tready) oidx_q <= oidx_q + 3'd1;
				default: ;
			endcase
			if (state_q == ST_ADD)
				for (int i = 0; i < 8; i++)
					cv_q[i] <= cv_q[i] + wk_q[255-32*i -: 32];
		end
	end

	always_ff @(posedge clk) begin
		if (bwe)
			word_q <= (bwaddr != fill_nx[5:2]) ? 32'd0 : bwdata;
		if (state_q == ST_ADD)
			word_q <= '0;
		if (state_q == ST_LOAD)
			wk_q <= {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4], cv_q[5], cv_q[6], cv_q[7]};
		if (state_q == ST_ROUND) begin
			wk_q <= rnext;
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= wt;
		end
	end

	// after the last compression the machine moves from ADD to OUT
	logic out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_q <= 1'b0;
		else if (state_q == ST_ADD && padding_q && !two_q)
			out_q <= 1'b1;
		else if (state_q == ST_OUT && m_axis_tready && oidx_q == 3'd7)
			out_q <= 1'b0;
	end

	assign m_axis_tvalid = (state_q == ST_IDLE) ? 1'b0 : (state_q == ST_OUT);
	assign m_axis_tdata = {5'd0, oidx_q, cv_q[oidx_q]};
	assign m_axis_tlast = (oidx_q == 3'd7);

	`SHA_ASSERT_IMP(a_out_busy, clk, arst_n, m_axis_tvalid, !s_axis_tready, "busy while out")
	`SHA_ASSERT_NXT(a_round_step, clk, arst_n, state_q == ST_ROUND && rnd_q != 7'd63,
		state_q == ST_ROUND, "round break")
	`SHA_ASSERT_IMP(a_out_flag, clk, arst_n, state_q == ST_OUT, out_q, "out flag")
endmodule

### hdl/sha256_ram.sv
module sha256_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### hdl/sha256_round.sv
module sha256_round (
	input  logic [255:0] abcd,
	input  logic [31:0]  kw,
	output logic [255:0] next
);
	logic [31:0] a, b, c, d, e, f, g, h, t1, t2;

	always_comb begin
		{a, b, c, d, e, f, g, h} = abcd;
		t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & f) ^ (~e & g)) + kw;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & b) ^ (a & c) ^ (b & c));
		next = {t1 + t2, a, b, c, d + t1, e, f, g};
	end
endmodule
